FILE: hw/rtl/bwt_block_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef BWT_BLOCK_DECODER_ASSERT_SVH
`define BWT_BLOCK_DECODER_ASSERT_SVH
// Implication checked on every rising edge outside reset.
`define BWTD_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bwtd implication failed");
// Next-cycle implication checked outside reset.
`define BWTD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bwtd next-cycle check failed");
`endif

FILE: hw/rtl/bwtd_pkg.sv
// Package for the block decoder: constants, commands, statuses, phases, queue entry type.
// Depends on nothing.
package bwtd_pkg;
  localparam int BlockRows = 1024;
  localparam int RowW = $clog2(BlockRows);
  localparam int CntW = RowW + 1;
  localparam int HdrBytes = 4;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0, CMD_FETCH = 2'd1, CMD_CLEAR = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_BADHDR = 2'd2, ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_HEADER, PH_DATA, PH_CHECK, PH_ZERO, PH_COUNT, PH_PREFIX, PH_MAP,
    PH_START, PH_WALK, PH_DONE, PH_BADHDR, PH_OVERFLOW, PH_FETCH, PH_FETCH2
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       last;
  } item_t;
endpackage

FILE: hw/rtl/bwtd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module bwtd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/bwtd_front.sv
// Front end: accepts items into a two-entry queue toward the back end.
// Depends on bwtd_pkg.
module bwtd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_command,
  input  logic [7:0]     in_data_byte,
  input  logic           in_block_end,
  output logic           q_valid,
  output bwtd_pkg::item_t q_item,
  input  logic           q_pop
);
  import bwtd_pkg::*;

  item_t      ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rd_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Queue pointers and storage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= !wr_r;
      end
      if (q_pop) begin
        rd_r <= !rd_r;
      end
    end
    if (push) begin
      ent_r[wr_r] <= '{cmd: in_command, data: in_data_byte, last: in_block_end};
    end
  end
endmodule

FILE: hw/rtl/bwtd_back.sv
// Back end: executes loads, clears, LF build by counting sort, and fetch walk steps.
// Depends on bwtd_pkg and bwtd_ram.
module bwtd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  bwtd_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic [9:0]      out_position,
  output logic            out_last,
  output logic [1:0]      status
);
  import bwtd_pkg::*;

  phase_t         ph_r, ph_nxt;
  logic [31:0]    hdr_r, hdr_nxt;
  logic [CntW-1:0] bc_r, bc_nxt;
  logic [RowW-1:0] row_r, row_nxt;
  logic [CntW-1:0] pos_r, pos_nxt;
  logic [CntW-1:0] ptr_r, ptr_nxt;
  logic [CntW-1:0] sum_r, sum_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      ob_r, ob_nxt;
  logic [9:0]      op_r, op_nxt;
  logic            ol_r, ol_nxt;
  logic [1:0]      os_r, os_nxt;
  logic            pop;

  // Last column, LF map and symbol counts memories.
  logic            lc_we, lf_we, sc_we;
  logic [RowW-1:0] lc_wa, lc_ra, lf_wa, lf_ra;
  logic [7:0]      lc_wd, lc_rd, sc_wa, sc_ra;
  logic [RowW-1:0] lf_wd, lf_rd;
  logic [CntW-1:0] sc_wd, sc_rd;

  bwtd_ram #(.Width(8), .Depth(BlockRows)) u_lc (
    .clk, .we(lc_we), .waddr(lc_wa), .wdata(lc_wd), .raddr(lc_ra), .rdata(lc_rd));
  bwtd_ram #(.Width(RowW), .Depth(BlockRows)) u_lf (
    .clk, .we(lf_we), .waddr(lf_wa), .wdata(lf_wd), .raddr(lf_ra), .rdata(lf_rd));
  bwtd_ram #(.Width(CntW), .Depth(256)) u_sc (
    .clk, .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd));

  logic [CntW-1:0] data_n, rows_n;
  logic [RowW-1:0] eof_row;
  logic            ptr_eof, ptr_after;
  logic [RowW-1:0] col_idx;

  assign data_n  = bc_r - CntW'(HdrBytes);
  assign rows_n  = data_n + CntW'(1);
  assign eof_row = hdr_r[RowW-1:0];
  assign ptr_eof = (ptr_r == CntW'(eof_row));
  assign ptr_after = (ptr_r > CntW'(eof_row));
  assign q_pop   = pop;

  // Column row for a matrix row: skip the sentinel row.
  function automatic logic [RowW-1:0] col_of(input logic [RowW-1:0] r,
                                              input logic [RowW-1:0] e);
    col_of = (r > e) ? r - RowW'(1) : r;
  endfunction

  // Phase sequencer.
  always_comb begin
    ph_nxt = ph_r; hdr_nxt = hdr_r; bc_nxt = bc_r; row_nxt = row_r;
    pos_nxt = pos_r; ptr_nxt = ptr_r; sum_nxt = sum_r; ov_nxt = ov_r;
    ob_nxt = ob_r; op_nxt = op_r; ol_nxt = ol_r; os_nxt = os_r;
    pop = 1'b0;
    lc_we = 1'b0; lc_wa = bc_r[RowW-1:0] - RowW'(HdrBytes); lc_wd = q_item.data;
    lc_ra = ptr_r[RowW-1:0];
    lf_we = 1'b0; lf_wa = ptr_r[RowW-1:0]; lf_wd = sc_rd[RowW-1:0];
    lf_ra = row_r;
    sc_we = 1'b0; sc_wa = ptr_r[7:0]; sc_wd = '0; sc_ra = ptr_r[7:0];
    col_idx = col_of(row_r, eof_row);
    if (out_valid && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (ph_r)
      PH_HEADER, PH_DATA, PH_DONE, PH_BADHDR, PH_OVERFLOW, PH_WALK: begin
        lc_ra = col_idx;
        if (q_valid && !(ov_r && !(out_valid && out_ready))) begin
          pop = 1'b1;
          case (q_item.cmd)
            CMD_CLEAR: begin
              ph_nxt = PH_HEADER; hdr_nxt = '0; bc_nxt = '0;
              row_nxt = '0; pos_nxt = '0;
            end
            CMD_LOAD: begin
              if (ph_r == PH_HEADER) begin
                hdr_nxt = hdr_r | ({24'd0, q_item.data} << (8 * bc_r[1:0]));
                bc_nxt = bc_r + CntW'(1);
                if (bc_r[1:0] == 2'd3) ph_nxt = PH_DATA;
                if (q_item.last) begin
                  if (bc_r[1:0] != 2'd3) begin
                    ph_nxt = PH_BADHDR; ov_nxt = 1'b1; os_nxt = ST_BADHDR;
                    ob_nxt = '0; op_nxt = '0; ol_nxt = 1'b0;
                  end else begin
                    ph_nxt = PH_CHECK;
                  end
                end
              end else if (ph_r == PH_DATA) begin
                if (data_n >= CntW'(BlockRows - 1)) begin
                  ph_nxt = PH_OVERFLOW; ov_nxt = 1'b1; os_nxt = ST_OVERFLOW;
                  ob_nxt = '0; op_nxt = '0; ol_nxt = 1'b0;
                end else begin
                  lc_we = 1'b1;
                  bc_nxt = bc_r + CntW'(1);
                  if (q_item.last) ph_nxt = PH_CHECK;
                end
              end
            end
            CMD_FETCH: begin
              ov_nxt = 1'b1; ob_nxt = '0; op_nxt = '0; ol_nxt = 1'b0;
              if (ph_r == PH_BADHDR) os_nxt = ST_BADHDR;
              else if (ph_r == PH_OVERFLOW) os_nxt = ST_OVERFLOW;
              else if (ph_r != PH_WALK) os_nxt = ST_EMPTY;
              else begin
                ov_nxt = 1'b0; ph_nxt = PH_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      PH_FETCH: begin
        // Column and LF reads land; result formed next cycle.
        lc_ra = col_idx;
        ph_nxt = PH_FETCH2;
      end
      PH_FETCH2: begin
        ov_nxt = 1'b1; os_nxt = ST_OK;
        ob_nxt = (row_r == eof_row) ? 8'd0 : lc_rd;
        op_nxt = pos_r[9:0]; ol_nxt = (pos_r == '0);
        row_nxt = lf_rd;
        if (pos_r == '0) ph_nxt = PH_DONE;
        else begin
          pos_nxt = pos_r - CntW'(1); ph_nxt = PH_WALK;
        end
      end
      PH_CHECK: begin
        if (hdr_r >= 32'(rows_n)) begin
          ph_nxt = PH_BADHDR; ov_nxt = 1'b1; os_nxt = ST_BADHDR;
          ob_nxt = '0; op_nxt = '0; ol_nxt = 1'b0;
        end else begin
          ptr_nxt = '0; ph_nxt = PH_ZERO;
        end
      end
      PH_ZERO: begin
        // Clear the 256 counters.
        sc_we = 1'b1; sc_wd = '0;
        ptr_nxt = ptr_r + CntW'(1);
        if (ptr_r == CntW'(255)) begin
          ptr_nxt = '0; sum_nxt = '0; ph_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        // Read-modify-write per column byte, stepped by sum_r[1:0].
        lc_ra = ptr_r[RowW-1:0];
        sc_ra = lc_rd; sc_wa = lc_rd; sc_wd = sc_rd + CntW'(1);
        if (ptr_r >= data_n) begin
          ptr_nxt = '0; sum_nxt = '0; ph_nxt = PH_PREFIX;
        end else begin
          case (sum_r[1:0])
            2'd0: sum_nxt = CntW'(1);
            2'd1: sum_nxt = CntW'(2);
            default: begin
              sc_we = 1'b1; sum_nxt = '0; ptr_nxt = ptr_r + CntW'(1);
            end
          endcase
        end
      end
      PH_PREFIX: begin
        // Exclusive prefix sum over the counters; row_r carries the phase.
        sc_ra = ptr_r[7:0]; sc_wa = ptr_r[7:0]; sc_wd = sum_r;
        if (row_r[0]) begin
          sc_we = 1'b1; sum_nxt = sum_r + sc_rd; row_nxt = '0;
          ptr_nxt = ptr_r + CntW'(1);
          if (ptr_r == CntW'(255)) begin
            ptr_nxt = '0; sum_nxt = '0; ph_nxt = PH_MAP;
          end
        end else begin
          row_nxt = RowW'(1);
        end
      end
      PH_MAP: begin
        // Stable assignment of LF rows, stepped by sum_r[1:0].
        lc_ra = col_of(ptr_r[RowW-1:0], eof_row);
        sc_ra = lc_rd; sc_wa = lc_rd; sc_wd = sc_rd + CntW'(1);
        lf_wd = ptr_eof ? RowW'(data_n) : sc_rd[RowW-1:0];
        if (ptr_r >= rows_n) begin
          ph_nxt = PH_START; row_nxt = eof_row;
        end else begin
          case (sum_r[1:0])
            2'd0: sum_nxt = CntW'(1);
            2'd1: sum_nxt = CntW'(2);
            default: begin
              lf_we = 1'b1; sc_we = !ptr_eof; sum_nxt = '0;
              ptr_nxt = ptr_r + CntW'(1);
            end
          endcase
        end
        if (ptr_after) col_idx = '0;
      end
      PH_START: begin
        // Read lf_map[eof]; row_r was set to eof.
        if (sum_r[0]) begin
          sum_nxt = '0; row_nxt = lf_rd;
          pos_nxt = data_n - CntW'(1);
          ph_nxt = (data_n == '0) ? PH_DONE : PH_WALK;
        end else begin
          sum_nxt = CntW'(1);
        end
      end
      default: ph_nxt = PH_HEADER;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HEADER; hdr_r <= '0; bc_r <= '0; row_r <= '0; pos_r <= '0;
      ptr_r <= '0; sum_r <= '0; ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; hdr_r <= hdr_nxt; bc_r <= bc_nxt; row_r <= row_nxt;
      pos_r <= pos_nxt; ptr_r <= ptr_nxt; sum_r <= sum_nxt; ov_r <= ov_nxt;
    end
    ob_r <= ob_nxt; op_r <= op_nxt; ol_r <= ol_nxt; os_r <= os_nxt;
  end

  assign out_valid    = ov_r;
  assign out_byte     = ob_r;
  assign out_position = op_r;
  assign out_last     = ol_r;
  assign status       = os_r;
endmodule

FILE: hw/rtl/bwt_block_decoder.sv
// Block decoder top level: front queue feeding the back-end sequencer.
// Depends on bwtd_pkg, bwtd_front, bwtd_back and the assertion header.
//
// Use: items enter on in_valid/in_ready with in_command (load, fetch, clear),
// in_data_byte and in_block_end. Results leave on out_valid/out_ready with
// out_byte, out_position, out_last and status; each result is one transfer.
// A two-entry queue lets the input side keep sending while the back end works.
// Each load is handled as it leaves the queue. The last load starts the LF
// build: the header check, a clear of the 256 counters, counting of the data
// bytes, the prefix sum over the counters, mapping of the rows, then the start
// of the walk; all run through the memories with one write and one read port.
// A fetch passes through PH_FETCH and PH_FETCH2 from leaving the queue to its
// result; the back end takes no new item until that result is accepted.
// Error and empty results appear in the cycle after the step that finds them.
// Reset empties the queue, drops any pending result and awaits a header.
// While the receiver stalls, the result holds and the back end stops;
// the queue then fills and in_ready falls.
`include "bwt_block_decoder_assert.svh"
module bwt_block_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_data_byte,
  input  logic       in_block_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [9:0] out_position,
  output logic       out_last,
  output logic [1:0] out_status
);
  import bwtd_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  bwtd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_data_byte, .in_block_end,
    .q_valid, .q_item, .q_pop);

  bwtd_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .out_valid, .out_ready, .out_byte,
    .out_position, .out_last, .status(out_status));

  // Pop only happens when something is queued.
  `BWTD_ASSERT_IMPL(a_pop_valid, q_pop, q_valid)
  // Nonzero status carries zero payload.
  `BWTD_ASSERT_IMPL(a_err_zero, out_valid && out_status != ST_OK,
                    out_byte == 8'd0 && out_position == 10'd0 && !out_last)
  // A stalled result stays put.
  `BWTD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_byte))
endmodule
